// ===== rtl/rcbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcbd_pkg: shared types and codes
// Opcodes, status codes and the result record used by the ring/chord engine.
// ----------------------------------------------------------------------------
package rcbd_pkg;

  localparam int unsigned NODE_W = 13;  // node number field width
  localparam int unsigned CNT_W  = 14;  // node counts up to 8192
  localparam int unsigned DIST_W = 12;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OP_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DIST_W-1:0] distance;
  } result_t;

endpackage

// ===== rtl/rcbd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcbd_ram: simple dual-port memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rcbd_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rcbd_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcbd_engine: chord table and breadth-first search sequencer
// Steps through clears, chord inserts and searches, taking a new command only when idle.
// ----------------------------------------------------------------------------
module rcbd_engine
  import rcbd_pkg::*;
#(
  parameter int unsigned MAX_NODES      = 4096,
  parameter int unsigned MAX_EDGE_SLOTS = 8192
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [NODE_W-1:0] node_count_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [NODE_W-1:0] node_a_i,
  input  logic [NODE_W-1:0] node_b_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output result_t           res_o
);

  localparam int unsigned AW_N   = $clog2(MAX_NODES);
  localparam int unsigned AW_E   = $clog2(MAX_EDGE_SLOTS);
  localparam int unsigned SLOT_W = $clog2(MAX_EDGE_SLOTS + 1);
  localparam int unsigned QW     = $clog2(MAX_NODES + 1);
  localparam int unsigned QE_W   = CNT_W + DIST_W;

  typedef enum logic [3:0] {
    S_IDLE, S_CLRH, S_ADD_RD, S_ADD_WR, S_VCLR, S_SRC, S_DEQ, S_DEQ_W,
    S_VRD, S_VCHK, S_HRD, S_HWAIT, S_ECHK, S_EWAIT, S_DONE
  } state_e;

  typedef enum logic [1:0] {V_PREV, V_NEXT, V_CHORD} vsel_e;

  state_e              state_q;
  vsel_e               vsel_q;
  logic [CNT_W-1:0]    from_q, to_q, dst_q, cur_q, vnode_q;
  logic                second_q, emit_q;
  logic [DIST_W-1:0]   d_q;
  logic [SLOT_W-1:0]   slot_q, used_q;
  logic [QW-1:0]       qh_q, qt_q;
  logic [AW_N-1:0]     clr_q;
  result_t             res_q;

  logic [CNT_W-1:0]    n_eff, a_ext, b_ext, prev_node, next_node, tgt;
  logic                a_ok, b_ok, t_ok;

  logic                head_we;
  logic [AW_N-1:0]     head_waddr, head_raddr;
  logic [SLOT_W-1:0]   head_wdata, head_rdata;
  logic                edge_we;
  logic [AW_E-1:0]     edge_waddr, edge_raddr;
  logic [SLOT_W+NODE_W-1:0] edge_wdata, edge_rdata;
  logic                vis_we, vis_wdata, vis_rdata;
  logic [AW_N-1:0]     vis_waddr, vis_raddr;
  logic                q_we;
  logic [AW_N-1:0]     q_waddr, q_raddr;
  logic [QE_W-1:0]     q_wdata, q_rdata;
  logic                vis_new;

  // Effective node count: clamp to [3, MAX_NODES].
  always_comb begin
    n_eff = {1'b0, node_count_i};
    if (n_eff < CNT_W'(3)) n_eff = CNT_W'(3);
    if (n_eff > CNT_W'(MAX_NODES)) n_eff = CNT_W'(MAX_NODES);
  end

  assign a_ext = {1'b0, node_a_i};
  assign b_ext = {1'b0, node_b_i};
  assign a_ok  = (a_ext != '0) && (a_ext <= n_eff);
  assign b_ok  = (b_ext != '0) && (b_ext <= n_eff);

  assign prev_node = (q_rdata[QE_W-1:DIST_W] == CNT_W'(1)) ? n_eff
                                                            : q_rdata[QE_W-1:DIST_W] - 1'b1;
  assign next_node = (cur_q >= n_eff) ? CNT_W'(1) : cur_q + 1'b1;
  assign tgt       = {1'b0, edge_rdata[NODE_W-1:0]};
  assign t_ok      = (tgt != '0) && (tgt <= n_eff);
  assign vis_new   = (state_q == S_VCHK) && !vis_rdata;

  // Memory port steering.
  always_comb begin
    head_we    = (state_q == S_CLRH) || (state_q == S_ADD_WR);
    head_waddr = (state_q == S_CLRH) ? clr_q : AW_N'(from_q - 1'b1);
    head_wdata = (state_q == S_CLRH) ? '0 : used_q + 1'b1;
    head_raddr = (state_q == S_HRD) ? AW_N'(cur_q - 1'b1) : AW_N'(from_q - 1'b1);

    edge_we    = (state_q == S_ADD_WR);
    edge_waddr = AW_E'(used_q);
    edge_wdata = {head_rdata, to_q[NODE_W-1:0]};
    edge_raddr = AW_E'(slot_q - 1'b1);

    vis_we    = (state_q == S_VCLR) || (state_q == S_SRC) || vis_new;
    vis_wdata = (state_q != S_VCLR);
    priority if (state_q == S_VCLR) vis_waddr = clr_q;
    else if (state_q == S_SRC)     vis_waddr = AW_N'(from_q - 1'b1);
    else                           vis_waddr = AW_N'(vnode_q - 1'b1);
    vis_raddr = AW_N'(vnode_q - 1'b1);

    q_we    = (state_q == S_SRC) || vis_new;
    q_waddr = (state_q == S_SRC) ? '0 : AW_N'(qt_q);
    q_wdata = (state_q == S_SRC) ? {from_q, {DIST_W{1'b0}}} : {vnode_q, d_q};
    q_raddr = AW_N'(qh_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLRH;
      emit_q   <= 1'b0;
      clr_q    <= '0;
      used_q   <= '0;
      second_q <= 1'b0;
      vsel_q   <= V_PREV;
      qh_q     <= '0;
      qt_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            res_q.distance <= '0;
            from_q   <= a_ext;
            to_q     <= b_ext;
            dst_q    <= b_ext;
            second_q <= 1'b0;
            clr_q    <= '0;
            emit_q   <= 1'b1;
            unique case (opcode_e'(opcode_i))
              OP_CLEAR: begin
                res_q.status <= ST_OK;
                used_q       <= '0;
                state_q      <= S_CLRH;
              end
              OP_ADD: begin
                priority if (!a_ok || !b_ok) begin
                  res_q.status <= ST_RANGE;
                  state_q      <= S_DONE;
                end else if ({1'b0, used_q} + 2'd2 > (SLOT_W+1)'(MAX_EDGE_SLOTS)) begin
                  res_q.status <= ST_FULL;
                  state_q      <= S_DONE;
                end else begin
                  res_q.status <= ST_OK;
                  state_q      <= S_ADD_RD;
                end
              end
              OP_QUERY: begin
                if (!a_ok || !b_ok) begin
                  res_q.status <= ST_RANGE;
                  state_q      <= S_DONE;
                end else begin
                  res_q.status <= ST_OK;
                  state_q      <= S_VCLR;
                end
              end
              default: begin
                res_q.status <= ST_OK;
                state_q      <= S_DONE;
              end
            endcase
          end
        end
        S_CLRH: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW_N'(MAX_NODES - 1)) begin
            state_q <= emit_q ? S_DONE : S_IDLE;
          end
        end
        S_ADD_RD: state_q <= S_ADD_WR;
        S_ADD_WR: begin
          used_q <= used_q + 1'b1;
          if (second_q) begin
            state_q <= S_DONE;
          end else begin
            // Second direction: swap endpoints.
            second_q <= 1'b1;
            from_q   <= to_q;
            to_q     <= from_q;
            state_q  <= S_ADD_RD;
          end
        end
        S_VCLR: begin
          clr_q <= clr_q + 1'b1;
          if (CNT_W'(clr_q) == n_eff - 1'b1) state_q <= S_SRC;
        end
        S_SRC: begin
          qh_q    <= '0;
          qt_q    <= QW'(1);
          state_q <= S_DEQ;
        end
        S_DEQ: begin
          if (qh_q == qt_q) begin
            state_q <= S_DONE;
          end else begin
            qh_q    <= qh_q + 1'b1;
            state_q <= S_DEQ_W;
          end
        end
        S_DEQ_W: begin
          cur_q <= q_rdata[QE_W-1:DIST_W];
          d_q   <= (q_rdata[DIST_W-1:0] == {DIST_W{1'b1}}) ? q_rdata[DIST_W-1:0]
                                                           : q_rdata[DIST_W-1:0] + 1'b1;
          if (q_rdata[QE_W-1:DIST_W] == dst_q) begin
            state_q <= S_DONE;
          end else begin
            vnode_q <= prev_node;
            vsel_q  <= V_PREV;
            state_q <= S_VRD;
          end
        end
        S_VRD: state_q <= S_VCHK;
        S_VCHK: begin
          if (!vis_rdata) begin
            qt_q <= qt_q + 1'b1;
            if (vnode_q == dst_q) res_q.distance <= d_q;
          end
          unique case (vsel_q)
            V_PREV: begin
              vnode_q <= next_node;
              vsel_q  <= V_NEXT;
              state_q <= S_VRD;
            end
            V_NEXT:  state_q <= S_HRD;
            default: begin
              slot_q  <= edge_rdata[SLOT_W+NODE_W-1:NODE_W];
              state_q <= S_ECHK;
            end
          endcase
        end
        S_HRD:   state_q <= S_HWAIT;
        S_HWAIT: begin
          slot_q  <= head_rdata;
          state_q <= S_ECHK;
        end
        S_ECHK: state_q <= (slot_q == '0) ? S_DEQ : S_EWAIT;
        S_EWAIT: begin
          if (t_ok) begin
            vnode_q <= tgt;
            vsel_q  <= V_CHORD;
            state_q <= S_VRD;
          end else begin
            slot_q  <= edge_rdata[SLOT_W+NODE_W-1:NODE_W];
            state_q <= S_ECHK;
          end
        end
        S_DONE: begin
          if (res_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  rcbd_ram #(.DEPTH(MAX_NODES), .WIDTH(SLOT_W)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .raddr_i(head_raddr), .rdata_o(head_rdata)
  );

  rcbd_ram #(.DEPTH(MAX_EDGE_SLOTS), .WIDTH(SLOT_W + NODE_W)) u_edge (
    .clk_i, .we_i(edge_we), .waddr_i(edge_waddr), .wdata_i(edge_wdata),
    .raddr_i(edge_raddr), .rdata_o(edge_rdata)
  );

  rcbd_ram #(.DEPTH(MAX_NODES), .WIDTH(1)) u_visited (
    .clk_i, .we_i(vis_we), .waddr_i(vis_waddr), .wdata_i(vis_wdata),
    .raddr_i(vis_raddr), .rdata_o(vis_rdata)
  );

  rcbd_ram #(.DEPTH(MAX_NODES), .WIDTH(QE_W)) u_queue (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .raddr_i(q_raddr), .rdata_o(q_rdata)
  );

endmodule

// ===== rtl/ring_chord_bfs_distance.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_chord_bfs_distance: hop-count engine on a ring with chords
// Stores undirected chords in a linked table and answers shortest-path
// queries with a breadth-first search run over on-chip memories.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         opcode, node_a, node_b
//  m_axis    out        distance, status
//  cfg       in         node_count (write only)
//
//  Clear sweeps the head table, one head entry per cycle; add reads the head of
//  each endpoint and links the chord in both directions; a query first clears
//  the visited marks of the live nodes, then dequeues nodes breadth-first and
//  checks both ring neighbours and every in-range chord target of each.
//  After reset the head table is swept before s_axis_tready rises; cfg writes
//  are taken at any time. The result sits in an output register, so the next
//  transaction is accepted while it waits on m_axis.
// ----------------------------------------------------------------------------
module ring_chord_bfs_distance
  import rcbd_pkg::*;
#(
  parameter int unsigned MAX_NODES      = 4096,
  parameter int unsigned MAX_EDGE_SLOTS = 8192
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,  // opcode[1:0], node_a[14:2], node_b[27:15]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,  // distance[11:0], status[13:12]
  input  logic              cfg_we_i,
  input  logic [NODE_W-1:0] cfg_wdata_i
);

  logic [NODE_W-1:0] node_count_q;
  logic              res_valid, res_ready;
  result_t           res;
  logic              m_valid_q;
  result_t           m_data_q;

  // Hold the node count register; reset to the smallest ring.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_W'(3);
    end else if (cfg_we_i) begin
      node_count_q <= cfg_wdata_i;
    end
  end

  rcbd_engine #(
    .MAX_NODES     (MAX_NODES),
    .MAX_EDGE_SLOTS(MAX_EDGE_SLOTS)
  ) u_engine (
    .clk_i,
    .rst_ni,
    .node_count_i(node_count_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .opcode_i    (s_axis_tdata[1:0]),
    .node_a_i    (s_axis_tdata[14:2]),
    .node_b_i    (s_axis_tdata[27:15]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: load when empty or being drained this cycle.
  assign res_ready = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_ready) begin
      m_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) m_data_q <= res;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, m_data_q.status, m_data_q.distance};

endmodule

// ===== verif/ring_chord_bfs_distance_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_chord_bfs_distance_checker: hop-count predictor and result scoreboard
// Watches the command and result channels and the node count register, keeps
// its own ring/chord graph and predicts each result with a breadth-first search.
// ----------------------------------------------------------------------------
module ring_chord_bfs_distance_checker
  import rcbd_pkg::*;
#(
  parameter int unsigned MAX_NODES      = 4096,
  parameter int unsigned MAX_EDGE_SLOTS = 8192
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [15:0]       m_axis_tdata,
  input  logic              cfg_we_i,
  input  logic [NODE_W-1:0] cfg_wdata_i,
  output int                fail_count_o,
  output int                pending_o
);

  logic [NODE_W-1:0] node_count_q;
  int unsigned       chord_head[MAX_NODES];
  int unsigned       chord_next[MAX_EDGE_SLOTS];
  int unsigned       chord_far[MAX_EDGE_SLOTS];
  int unsigned       slots_used;
  result_t           hop_results[$];

  assign pending_o = hop_results.size();

  function automatic int unsigned active_nodes();
    int unsigned n;
    n = node_count_q;
    if (n < 3) n = 3;
    if (n > MAX_NODES) n = MAX_NODES;
    return n;
  endfunction

  function automatic int unsigned hop_count(int unsigned src, int unsigned dst,
                                            int unsigned n);
    bit          seen[];
    int unsigned hop_dist[];
    int unsigned fifo[$];
    int unsigned cur, d, s, guard, nb[2];
    seen = new[MAX_NODES];
    hop_dist = new[MAX_NODES];
    seen[src-1] = 1;
    hop_dist[src-1] = 0;
    fifo.push_back(src);
    while (fifo.size() > 0) begin
      cur = fifo.pop_front();
      if (cur == dst) break;
      d = hop_dist[cur-1] + 1;
      nb[0] = (cur == 1) ? n : cur - 1;
      nb[1] = (cur >= n) ? 1 : cur + 1;
      foreach (nb[i]) begin
        if (!seen[nb[i]-1]) begin
          seen[nb[i]-1] = 1;
          hop_dist[nb[i]-1] = d;
          fifo.push_back(nb[i]);
        end
      end
      // walk chords newest first, skip targets beyond the live ring
      s = chord_head[cur-1];
      guard = 0;
      while (s != 0 && s <= slots_used && guard < MAX_EDGE_SLOTS) begin
        if (chord_far[s-1] >= 1 && chord_far[s-1] <= n && !seen[chord_far[s-1]-1]) begin
          seen[chord_far[s-1]-1] = 1;
          hop_dist[chord_far[s-1]-1] = d;
          fifo.push_back(chord_far[s-1]);
        end
        s = chord_next[s-1];
        guard++;
      end
    end
    if (!seen[dst-1]) return 0;
    return (hop_dist[dst-1] > 4095) ? 4095 : hop_dist[dst-1];
  endfunction

  task automatic store_half(int unsigned from, int unsigned to);
    chord_next[slots_used] = chord_head[from-1];
    chord_far[slots_used]  = to;
    slots_used++;
    chord_head[from-1]     = slots_used;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    opcode_e     op;
    int unsigned a, b, n;
    result_t     want, got;
    if (!rst_ni) begin
      node_count_q = 3;
      foreach (chord_head[i]) chord_head[i] = 0;
      slots_used   = 0;
      hop_results.delete();
      fail_count_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[13:0];
        if (hop_results.size() == 0) begin
          $error("unexpected result distance=%0d status=%0d", got.distance, got.status);
          fail_count_o++;
        end else begin
          want = hop_results.pop_front();
          if (got.distance !== want.distance) begin
            $error("distance: expected %0d, actual %0d", want.distance, got.distance);
            fail_count_o++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        op = opcode_e'(s_axis_tdata[1:0]);
        a  = s_axis_tdata[14:2];
        b  = s_axis_tdata[27:15];
        n  = active_nodes();
        want = '0;
        unique case (op)
          OP_CLEAR: begin
            foreach (chord_head[i]) chord_head[i] = 0;
            slots_used = 0;
          end
          OP_ADD: begin
            if (a < 1 || a > n || b < 1 || b > n) want.status = ST_RANGE;
            else if (slots_used + 2 > MAX_EDGE_SLOTS) want.status = ST_FULL;
            else begin
              store_half(a, b);
              store_half(b, a);
            end
          end
          OP_QUERY: begin
            if (a < 1 || a > n || b < 1 || b > n) want.status = ST_RANGE;
            else want.distance = hop_count(a, b, n);
          end
          default: ;
        endcase
        hop_results.push_back(want);
      end
      if (cfg_we_i) node_count_q = cfg_wdata_i;
    end
  end

endmodule

// ===== verif/ring_chord_bfs_distance_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_chord_bfs_distance_test: stimulus and verdict for the hop-count engine
// Drives clear, add and query commands in bursts over several node counts,
// stalls the result side on its own pattern and lets the checker score it.
// ----------------------------------------------------------------------------
module ring_chord_bfs_distance_test;
  import rcbd_pkg::*;

  localparam int unsigned WATCHDOG  = 400000;  // idle cycles; a max-size clear/query fits

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata = '0;   // opcode[1:0], node_a[14:2], node_b[27:15]
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;        // distance[11:0], status[13:12]
  logic              cfg_we_i = 1'b0;
  logic [NODE_W-1:0] cfg_wdata_i = '0;
  int                fail_count, pending;
  int                idle_cycles = 0;
  bit                hold_off = 1'b0;     // long receiver stall request
  bit                draining = 1'b0;     // end of stimulus, stop stalling

  always #2 clk_i = ~clk_i;

  ring_chord_bfs_distance dut (.*);

  ring_chord_bfs_distance_checker scoreboard (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver: random stall pattern, with long hold-off when requested.
  always @(posedge clk_i) begin
    if (hold_off) begin
      m_axis_tready <= 1'b0;
    end else if (draining) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Watchdog: count cycles without any transaction.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > WATCHDOG) begin
      $display("** ring_chord_bfs_distance: FAILED **");
      $finish;
    end
  end

  // Offer one command and hold it until the engine takes it.
  task automatic send_cmd(opcode_e op, int unsigned a, int unsigned b);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, b[12:0], a[12:0], op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Drop valid for a random gap after a burst.
  task automatic burst_gap();
    int unsigned gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Wait out every pending result, then settle before a register write.
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_nodes(int unsigned n);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= n[12:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Random phase: mostly chords and queries on nodes in range, some noise.
  task automatic random_phase(int unsigned count, int unsigned n);
    int unsigned burst, k, a, b, pick;
    opcode_e     op;
    k = 0;
    while (k < count) begin
      burst = $urandom_range(1, 8);
      repeat (burst) begin
        pick = $urandom_range(0, 19);
        if (pick < 8) op = OP_ADD;
        else if (pick < 18) op = OP_QUERY;
        else if (pick < 19) op = OP_CLEAR;
        else op = OP_NONE;
        a = $urandom_range(1, n);
        b = $urandom_range(1, n);
        if ($urandom_range(0, 15) == 0) a = $urandom_range(0, 8191);
        if ($urandom_range(0, 15) == 0) b = $urandom_range(0, 8191);
        send_cmd(op, a, b);
        k++;
      end
      burst_gap();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: default three-node ring, range errors, unused opcode.
    send_cmd(OP_QUERY, 1, 3);
    send_cmd(OP_QUERY, 2, 2);
    send_cmd(OP_QUERY, 0, 1);
    send_cmd(OP_ADD, 4, 1);
    send_cmd(OP_ADD, 8191, 8191);
    send_cmd(OP_NONE, 8191, 8191);
    send_cmd(OP_ADD, 1, 1);
    wait_quiet();

    // Node count below the floor is raised to three.
    set_nodes(0);
    send_cmd(OP_QUERY, 1, 3);
    send_cmd(OP_QUERY, 3, 4);
    wait_quiet();

    // Largest ring: far pair, then a chord that shortcuts it, self and dup chord.
    set_nodes(8191);
    send_cmd(OP_QUERY, 1, 2049);
    send_cmd(OP_QUERY, 4096, 4097);
    send_cmd(OP_ADD, 1, 2049);
    send_cmd(OP_ADD, 1, 2049);
    send_cmd(OP_ADD, 4096, 4096);
    send_cmd(OP_QUERY, 4096, 2048);
    send_cmd(OP_QUERY, 2049, 1);
    wait_quiet();

    // Shrink: chord to 2049 goes stale and is skipped.
    set_nodes(40);
    send_cmd(OP_QUERY, 1, 20);
    send_cmd(OP_ADD, 5, 30);
    send_cmd(OP_QUERY, 1, 30);
    send_cmd(OP_CLEAR, 0, 0);
    send_cmd(OP_QUERY, 1, 20);
    wait_quiet();

    // Long receiver hold-off while the sender keeps offering.
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      random_phase(10, 40);
    join
    wait_quiet();

    set_nodes(64);
    random_phase(40, 64);
    wait_quiet();

    set_nodes(3);
    random_phase(15, 3);
    wait_quiet();

    set_nodes(17);
    random_phase(35, 17);

    draining = 1'b1;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** ring_chord_bfs_distance: PASSED **");
    end else begin
      $display("** ring_chord_bfs_distance: FAILED **");
    end
    $finish;
  end

endmodule
